// ===== src/rhsv_pkg.sv =====
package rhsv_pkg;

  localparam int unsigned PIX_W      = 8;
  localparam int unsigned Q_W        = 8;
  localparam int unsigned DIV_STAGES = Q_W;
  localparam int unsigned NUM_W      = 18;
  localparam int unsigned DEN_W      = 10;
  localparam int unsigned HN_W       = 11;
  localparam int unsigned HUE_SHIFT  = 7;
  localparam int unsigned SAT_NUM_W  = 16;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W     = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W     = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [NUM_W-1:0]     hue_num;
    logic [DEN_W-1:0]     hue_den;
    logic [SAT_NUM_W-1:0] sat_num;
    logic [PIX_W-1:0]     sat_den;
    logic [PIX_W-1:0]     bright;
  } entry_t;

  typedef struct packed {
    logic full;
    logic not_empty;
  } queue_status_t;

endpackage

// ===== src/rgb_to_hsv_pixel.sv =====
// rgb_to_hsv_pixel: converts one 8-bit rgb pixel to hue, saturation and
// brightness bytes.
// input beat: red, green and blue are taken at a rising edge where start is
// high and busy is low. a new pixel may be given every cycle while busy is low.
// result beat: done is high for exactly one cycle with hue, saturation and
// brightness valid in that cycle; the receiver cannot hold results off.
// pipeline: a taken pixel passes one register stage for max, min and
// sector, one in the two-entry queue, and eight in the pipelined dividers,
// which resolve one quotient bit per stage. done rises with the last divider stage.
// throughput: one pixel per cycle. the back end never stalls, so the queue
// drains as fast as it fills and busy stays low in normal use; busy only
// rises if the queue were ever full.
// reset: rst is synchronous and active high; it drops all pixels in flight
// and no done strobe appears until new pixels have gone through.
module rgb_to_hsv_pixel (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [rhsv_pkg::PIX_W-1:0] red,
  input  logic [rhsv_pkg::PIX_W-1:0] green,
  input  logic [rhsv_pkg::PIX_W-1:0] blue,
  output logic                       done,
  output logic [rhsv_pkg::PIX_W-1:0] hue,
  output logic [rhsv_pkg::PIX_W-1:0] saturation,
  output logic [rhsv_pkg::PIX_W-1:0] brightness
);

  logic                    push;
  rhsv_pkg::entry_t        front_entry;
  rhsv_pkg::entry_t        head;
  rhsv_pkg::queue_status_t q_status;

  rhsv_front u_front (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .red    (red),
    .green  (green),
    .blue   (blue),
    .q_full (q_status.full),
    .busy   (busy),
    .push   (push),
    .entry  (front_entry)
  );

  rhsv_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .entry_in (front_entry),
    .pop      (q_status.not_empty),
    .status   (q_status),
    .head     (head)
  );

  rhsv_back u_back (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (q_status.not_empty),
    .entry      (head),
    .done       (done),
    .hue        (hue),
    .saturation (saturation),
    .brightness (brightness)
  );

endmodule

// ===== src/rhsv_front.sv =====
module rhsv_front (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [rhsv_pkg::PIX_W-1:0] red,
  input  logic [rhsv_pkg::PIX_W-1:0] green,
  input  logic [rhsv_pkg::PIX_W-1:0] blue,
  input  logic                     q_full,
  output logic                     busy,
  output logic                     push,
  output rhsv_pkg::entry_t         entry
);

  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_t;

  logic                          vld;
  logic                          advance;
  logic [rhsv_pkg::PIX_W-1:0]    mx;
  logic [rhsv_pkg::PIX_W-1:0]    mn;
  logic [rhsv_pkg::PIX_W-1:0]    d;
  sector_t                       sector;
  logic [rhsv_pkg::HN_W-1:0]     d2;
  logic [rhsv_pkg::HN_W-1:0]     d3;
  logic [rhsv_pkg::HN_W-1:0]     d4;
  logic [rhsv_pkg::HN_W-1:0]     d6;
  logic [rhsv_pkg::HN_W-1:0]     hn;
  rhsv_pkg::entry_t              entry_next;

  always_comb begin
    mx = red;
    mn = red;
    if (green > mx) mx = green;
    if (blue > mx) mx = blue;
    if (green < mn) mn = green;
    if (blue < mn) mn = blue;
    d = mx - mn;
    if (mx == red) begin
      sector = SEC_RED;
    end else if (mx == green) begin
      sector = SEC_GREEN;
    end else begin
      sector = SEC_BLUE;
    end
  end

  always_comb begin
    d2 = {2'b00, d, 1'b0};
    d3 = d2 + rhsv_pkg::HN_W'(d);
    d4 = {1'b0, d, 2'b00};
    d6 = {d3[rhsv_pkg::HN_W-2:0], 1'b0};
    unique case (sector)
      SEC_RED: begin
        if (green >= blue) begin
          hn = rhsv_pkg::HN_W'(green) - rhsv_pkg::HN_W'(blue);
        end else begin
          // wrap round the circle
          hn = d6 + rhsv_pkg::HN_W'(green) - rhsv_pkg::HN_W'(blue);
        end
      end
      SEC_GREEN: begin
        hn = d2 + rhsv_pkg::HN_W'(blue) - rhsv_pkg::HN_W'(red);
      end
      SEC_BLUE: begin
        hn = d4 + rhsv_pkg::HN_W'(red) - rhsv_pkg::HN_W'(green);
      end
      default: begin
        hn = '0;
      end
    endcase
  end

  always_comb begin
    entry_next.hue_num = rhsv_pkg::NUM_W'(hn) << rhsv_pkg::HUE_SHIFT;
    entry_next.hue_den = (d == '0) ? rhsv_pkg::DEN_W'(1) : rhsv_pkg::DEN_W'(d3);
    entry_next.sat_num = {d, {rhsv_pkg::PIX_W{1'b0}}} - rhsv_pkg::SAT_NUM_W'(d);
    entry_next.sat_den = (mx == '0) ? rhsv_pkg::PIX_W'(1) : mx;
    entry_next.bright  = mx;
  end

  assign advance = !vld || !q_full;
  assign busy    = !advance;
  assign push    = vld && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (advance) begin
      vld <= start;
    end
    if (advance && start) begin
      entry <= entry_next;
    end
  end

endmodule

// ===== src/rhsv_queue.sv =====
module rhsv_queue (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  rhsv_pkg::entry_t        entry_in,
  input  logic                    pop,
  output rhsv_pkg::queue_status_t status,
  output rhsv_pkg::entry_t        head
);

  rhsv_pkg::entry_t              mem [rhsv_pkg::QUEUE_DEPTH];
  logic [rhsv_pkg::QPTR_W-1:0]   wr_ptr;
  logic [rhsv_pkg::QPTR_W-1:0]   rd_ptr;
  logic [rhsv_pkg::QCNT_W-1:0]   count;
  logic [rhsv_pkg::QCNT_W-1:0]   count_next;
  logic                          do_push;
  logic                          do_pop;

  assign status.full      = (count == rhsv_pkg::QCNT_W'(rhsv_pkg::QUEUE_DEPTH));
  assign status.not_empty = (count != '0);
  assign do_push          = push && !status.full;
  assign do_pop           = pop && status.not_empty;
  assign head             = mem[rd_ptr];

  always_comb begin
    count_next = count;
    if (do_push && !do_pop) count_next = count + rhsv_pkg::QCNT_W'(1);
    if (do_pop && !do_push) count_next = count - rhsv_pkg::QCNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (do_push) wr_ptr <= wr_ptr + rhsv_pkg::QPTR_W'(1);
      if (do_pop) rd_ptr <= rd_ptr + rhsv_pkg::QPTR_W'(1);
    end
    if (do_push) begin
      mem[wr_ptr] <= entry_in;
    end
  end

endmodule

// ===== src/rhsv_div.sv =====
module rhsv_div (
  input  logic                       clk,
  input  logic [rhsv_pkg::NUM_W-1:0] num,
  input  logic [rhsv_pkg::DEN_W-1:0] den,
  output logic [rhsv_pkg::Q_W-1:0]   quo
);

  logic [rhsv_pkg::NUM_W-1:0] rem_r [rhsv_pkg::DIV_STAGES];
  logic [rhsv_pkg::DEN_W-1:0] den_r [rhsv_pkg::DIV_STAGES];
  logic [rhsv_pkg::Q_W-1:0]   quo_r [rhsv_pkg::DIV_STAGES];

  // one quotient bit per stage, most significant first
  for (genvar k = 0; k < rhsv_pkg::DIV_STAGES; k++) begin : g_stage
    logic [rhsv_pkg::NUM_W-1:0] rem_in;
    logic [rhsv_pkg::DEN_W-1:0] den_in;
    logic [rhsv_pkg::Q_W-1:0]   quo_in;
    logic [rhsv_pkg::NUM_W-1:0] den_sh;

    if (k == 0) begin : g_first
      assign rem_in = num;
      assign den_in = den;
      assign quo_in = '0;
    end else begin : g_rest
      assign rem_in = rem_r[k-1];
      assign den_in = den_r[k-1];
      assign quo_in = quo_r[k-1];
    end

    assign den_sh = rhsv_pkg::NUM_W'(den_in) << (rhsv_pkg::DIV_STAGES - 1 - k);

    always_ff @(posedge clk) begin
      den_r[k] <= den_in;
      if (rem_in >= den_sh) begin
        rem_r[k] <= rem_in - den_sh;
        quo_r[k] <= quo_in | (rhsv_pkg::Q_W'(1) << (rhsv_pkg::DIV_STAGES - 1 - k));
      end else begin
        rem_r[k] <= rem_in;
        quo_r[k] <= quo_in;
      end
    end
  end

  assign quo = quo_r[rhsv_pkg::DIV_STAGES-1];

endmodule

// ===== src/rhsv_back.sv =====
module rhsv_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  rhsv_pkg::entry_t           entry,
  output logic                       done,
  output logic [rhsv_pkg::PIX_W-1:0] hue,
  output logic [rhsv_pkg::PIX_W-1:0] saturation,
  output logic [rhsv_pkg::PIX_W-1:0] brightness
);

  logic                       vld_r    [rhsv_pkg::DIV_STAGES];
  logic [rhsv_pkg::PIX_W-1:0] bright_r [rhsv_pkg::DIV_STAGES];

  rhsv_div u_hue_div (
    .clk (clk),
    .num (entry.hue_num),
    .den (entry.hue_den),
    .quo (hue)
  );

  rhsv_div u_sat_div (
    .clk (clk),
    .num (rhsv_pkg::NUM_W'(entry.sat_num)),
    .den (rhsv_pkg::DEN_W'(entry.sat_den)),
    .quo (saturation)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < rhsv_pkg::DIV_STAGES; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else begin
      vld_r[0] <= in_valid;
      for (int i = 1; i < rhsv_pkg::DIV_STAGES; i++) begin
        vld_r[i] <= vld_r[i-1];
      end
    end
    bright_r[0] <= entry.bright;
    for (int i = 1; i < rhsv_pkg::DIV_STAGES; i++) begin
      bright_r[i] <= bright_r[i-1];
    end
  end

  assign done       = vld_r[rhsv_pkg::DIV_STAGES-1];
  assign brightness = bright_r[rhsv_pkg::DIV_STAGES-1];

endmodule

// ===== src/rhsv_checker.sv =====
module rhsv_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       start,
  input logic                       busy,
  input logic                       done,
  input logic [rhsv_pkg::PIX_W-1:0] hue,
  input logic [rhsv_pkg::PIX_W-1:0] saturation,
  input logic [rhsv_pkg::PIX_W-1:0] brightness
);

  a_done_has_beat: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy && !rst, 10))
    else $error("result beat without a pixel taken ten cycles before");

  a_never_busy: assert property (@(posedge clk) disable iff (rst)
    !busy)
    else $error("busy raised although the back end never stalls");

  a_grey_hue: assert property (@(posedge clk) disable iff (rst)
    (done && saturation == '0) |-> (hue == '0))
    else $error("grey pixel with nonzero hue");

  a_black: assert property (@(posedge clk) disable iff (rst)
    (done && brightness == '0) |-> (saturation == '0 && hue == '0))
    else $error("black pixel with nonzero hue or saturation");

  a_quiet_after_reset: assert property (@(posedge clk)
    (!rst && $past(rst)) |-> !done)
    else $error("result beat right after reset");

endmodule

bind rgb_to_hsv_pixel rhsv_checker u_rhsv_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .done       (done),
  .hue        (hue),
  .saturation (saturation),
  .brightness (brightness)
);

// ===== tb/sv/tb_rgb_to_hsv_pixel.sv =====
`timescale 1ns / 100ps

module tb_rgb_to_hsv_pixel;

  localparam int unsigned PIX_W = rhsv_pkg::PIX_W;
  localparam int STALL_LIMIT = 1000;
  localparam int TAIL_CYCLES = 16;
  localparam int RANDOM_ITEMS = 1700;

  typedef struct packed {
    logic [PIX_W-1:0] hue;
    logic [PIX_W-1:0] saturation;
    logic [PIX_W-1:0] brightness;
  } hsv_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [PIX_W-1:0] red = '0;
  logic [PIX_W-1:0] green = '0;
  logic [PIX_W-1:0] blue = '0;
  logic done;
  logic [PIX_W-1:0] hue;
  logic [PIX_W-1:0] saturation;
  logic [PIX_W-1:0] brightness;

  hsv_t pending_hsv[$];
  int error_count = 0;
  int quiet_cycles = 0;

  rgb_to_hsv_pixel dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .done       (done),
    .hue        (hue),
    .saturation (saturation),
    .brightness (brightness)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic hsv_t convert_pixel(input logic [PIX_W-1:0] r, g, b);
    int mx;
    int mn;
    int d;
    int offset;
    int diff;
    int num;
    int den;
    hsv_t res;
    mx = r;
    mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    d = mx - mn;
    res.brightness = mx[PIX_W-1:0];
    res.saturation = (mx == 0) ? '0 : PIX_W'((255 * d) / mx);
    if (d == 0) begin
      res.hue = '0;
    end else begin
      // sector priority: red, then green, then blue
      if (mx == r) begin
        offset = 0;
        diff = int'(g) - int'(b);
      end else if (mx == g) begin
        offset = 2;
        diff = int'(b) - int'(r);
      end else begin
        offset = 4;
        diff = int'(r) - int'(g);
      end
      den = 3 * d;
      num = 128 * (offset * d + diff);
      if (num < 0) num += 256 * den;
      res.hue = PIX_W'(num / den);
    end
    return res;
  endfunction

  // one input beat; returns at the edge that takes it
  task automatic send_pixel(input logic [PIX_W-1:0] r, g, b);
    start <= 1'b1;
    red <= r;
    green <= g;
    blue <= b;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_hsv.push_back(convert_pixel(r, g, b));
  endtask

  task automatic idle_cycles(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic wait_drained;
    start <= 1'b0;
    while (pending_hsv.size() != 0) @(posedge clk);
  endtask

  task automatic send_random_pixel;
    logic [PIX_W-1:0] ch[3];
    int mode;
    int base;
    int v;
    int rot;
    mode = $urandom_range(0, 6);
    base = $urandom_range(0, 255);
    for (int i = 0; i < 3; i++) begin
      case (mode)
        0, 1, 2: begin
          ch[i] = PIX_W'($urandom_range(0, 255));
        end
        3: begin
          // near grey
          v = base + $urandom_range(0, 6) - 3;
          if (v < 0) v = 0;
          if (v > 255) v = 255;
          ch[i] = v[PIX_W-1:0];
        end
        4: begin
          // two channels tie for the maximum
          ch[i] = (i < 2) ? base[PIX_W-1:0] : PIX_W'($urandom_range(0, base));
        end
        5: begin
          ch[i] = (i == 0) ? PIX_W'($urandom_range(0, 1) * 255) : PIX_W'($urandom_range(0, 255));
        end
        default: begin
          ch[i] = PIX_W'($urandom_range(0, 3));
        end
      endcase
    end
    rot = $urandom_range(0, 2);
    send_pixel(ch[rot], ch[(rot + 1) % 3], ch[(rot + 2) % 3]);
  endtask

  task automatic test_directed;
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd128, 8'd128, 8'd128);
    send_pixel(8'd255, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd255);
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd255);
    send_pixel(8'd200, 8'd200, 8'd10);
    send_pixel(8'd10, 8'd200, 8'd200);
    send_pixel(8'd200, 8'd10, 8'd200);
    send_pixel(8'd1, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd1);
    send_pixel(8'd255, 8'd0, 8'd1);
    send_pixel(8'd255, 8'd254, 8'd0);
    send_pixel(8'd1, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd1, 8'd255);
    send_pixel(8'haa, 8'h55, 8'haa);
    send_pixel(8'h55, 8'haa, 8'h55);
    send_pixel(8'd255, 8'd1, 8'd254);
    send_pixel(8'd2, 8'd1, 8'd1);
  endtask

  task automatic test_random_with_gaps;
    bit gaps_on;
    gaps_on = 1'b1;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if ($urandom_range(0, 39) == 0) gaps_on = ~gaps_on;
      send_random_pixel();
      if (gaps_on && $urandom_range(0, 2) == 0) idle_cycles($urandom_range(1, 9));
    end
  endtask

  task automatic test_pause_until_drained;
    for (int k = 0; k < 4; k++) begin
      repeat ($urandom_range(5, 20)) send_random_pixel();
      wait_drained();
    end
  endtask

  task automatic test_back_to_back;
    repeat (120) send_random_pixel();
  endtask

  always @(posedge clk) begin
    hsv_t want;
    if (!rst && done) begin
      if (pending_hsv.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual hue %0d sat %0d val %0d",
                 $time, hue, saturation, brightness);
        error_count++;
      end else begin
        want = pending_hsv.pop_front();
        if (hue !== want.hue) begin
          $display("%0t: hue expected %0d actual %0d", $time, want.hue, hue);
          error_count++;
        end
        if (saturation !== want.saturation) begin
          $display("%0t: saturation expected %0d actual %0d",
                   $time, want.saturation, saturation);
          error_count++;
        end
        if (brightness !== want.brightness) begin
          $display("%0t: brightness expected %0d actual %0d",
                   $time, want.brightness, brightness);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || done || (start && !busy)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst = 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_with_gaps();
    test_pause_until_drained();
    test_back_to_back();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/rhsv_pkg.sv
src/rhsv_front.sv
src/rhsv_queue.sv
src/rhsv_div.sv
src/rhsv_back.sv
src/rgb_to_hsv_pixel.sv
src/rhsv_checker.sv
tb/sv/tb_rgb_to_hsv_pixel.sv
